// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros: assertion helper macros
// Clocked assertion wrappers for the pixel classifier RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Assert a property on the rising clock edge, disabled in reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Assert a property on the rising clock edge, also during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- hw/rtl/vpc_pkg.sv -----
// ----------------------------------------------------------------------------
// vpc_pkg: shared types and constants
// Opcodes, register indexes, the sequencer state type and color helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package vpc_pkg;
   localparam logic OP_CLASSIFY = 1'b0;
   localparam logic OP_LOAD     = 1'b1;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_COLOR_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DIST_THR   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_CNT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_REQ_MATCH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UPD_RATE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FRM_WIDTH  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FRM_HEIGHT = 3'd6;

   localparam int PIX_W = 24;
   localparam int CSR_DATA_W = 9;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_COMPARE,
      ST_SELF_WR,
      ST_NBR_WR,
      ST_OUT
   } seq_state_type;

   // Absolute difference of two channel values.
   function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/vibe_pixel_classifier.sv -----
// ----------------------------------------------------------------------------
// vibe_pixel_classifier: sample-consensus background classifier
// Raster pixel classification against stored background samples.
// ----------------------------------------------------------------------------
// Every sample of every pixel is one word of a single-port sample RAM. A load
// item writes its word in the self write step. A classify item reads and tests
// one sample at a time (read, registered compare, count), and testing stops
// once enough samples match or every sample in use is tested; a background
// pixel always passes through the neighbor write step as well. The update
// draws are reduced by a serial remainder unit over their 16 bits, and a
// classify item waits in the self write step until that unit is done. One item
// is in work at a time; the finished result waits in the output register while
// the next item is accepted, and a result that is still waiting holds the
// following classify item in its last step.
`default_nettype none
`include "assert_macros.svh"
module vibe_pixel_classifier #(
   parameter int MAX_SAMPLES = 32,
   parameter int MAX_WIDTH   = 256,
   parameter int MAX_HEIGHT  = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_opcode,
   input  wire logic [7:0]  req_red,
   input  wire logic [7:0]  req_green,
   input  wire logic [7:0]  req_blue,
   input  wire logic [4:0]  req_load_slot,
   input  wire logic [15:0] req_load_address,
   input  wire logic [15:0] req_self_draw,
   input  wire logic [15:0] req_self_slot_draw,
   input  wire logic [15:0] req_nbr_draw,
   input  wire logic [2:0]  req_nbr_dir,
   input  wire logic [15:0] req_nbr_slot_draw,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_foreground,
   output logic [5:0]       rsp_match_count,
   output logic [15:0]      rsp_pixel_index,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [vpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [vpc_pkg::CSR_DATA_W-1:0] csr_data
);
   localparam int WB    = (MAX_WIDTH  < 256) ? MAX_WIDTH  : 256;
   localparam int HB    = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
   localparam int PLANE = MAX_WIDTH * MAX_HEIGHT;
   localparam int PL_W  = $clog2(PLANE);
   localparam int SL_W  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int DEPTH = MAX_SAMPLES * PLANE;
   localparam int AD_W  = $clog2(DEPTH);

   // Configuration registers
   logic       color_mode_ff;
   logic [7:0] dist_thr_ff;
   logic [5:0] sample_cnt_ff, req_match_ff;
   logic [8:0] upd_rate_ff, frm_width_ff, frm_height_ff;

   // Raster position and sequencer
   logic [7:0] col_ff, col_in, line_ff, line_in;
   vpc_pkg::seq_state_type state_ff, state_in;

   // Item registers
   logic        op_ff;
   logic [23:0] pix_ff;
   logic [4:0]  lslot_ff;
   logic [15:0] laddr_ff;
   logic [2:0]  dir_ff;
   logic [15:0] idx_ff;
   logic [7:0]  x_ff, y_ff;
   logic [6:0]  slot_ff, slot_in;
   logic [5:0]  match_ff, match_in;

   // Result register
   logic        rsp_valid_ff;
   logic        fg_ff;
   logic [5:0]  mc_ff;
   logic [15:0] pidx_ff;
   logic        rsp_load;
   logic        out_free;

   // Effective settings
   logic [8:0]  w_eff, h_eff, rate;
   logic [6:0]  n_eff;
   always_comb begin
      w_eff = (frm_width_ff == 9'd0) ? 9'd1 :
              (frm_width_ff > 9'(WB)) ? 9'(WB) : frm_width_ff;
      h_eff = (frm_height_ff == 9'd0) ? 9'd1 :
              (frm_height_ff > 9'(HB)) ? 9'(HB) : frm_height_ff;
      n_eff = (sample_cnt_ff == 6'd0) ? 7'd1 :
              (7'(sample_cnt_ff) > 7'(MAX_SAMPLES)) ? 7'(MAX_SAMPLES) : 7'(sample_cnt_ff);
      rate  = (upd_rate_ff == 9'd0) ? 9'd1 : upd_rate_ff;
   end

   logic accept;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   // The output register can take a new result this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Configuration writes; frame size writes restart the raster
   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff <= 1'b1;
         dist_thr_ff   <= 8'd20;
         sample_cnt_ff <= 6'd20;
         req_match_ff  <= 6'd2;
         upd_rate_ff   <= 9'd16;
         frm_width_ff  <= 9'd256;
         frm_height_ff <= 9'd256;
      end else if (csr_valid) begin
         case (csr_index)
            vpc_pkg::REG_COLOR_MODE: color_mode_ff <= csr_data[0];
            vpc_pkg::REG_DIST_THR:   dist_thr_ff   <= csr_data[7:0];
            vpc_pkg::REG_SAMPLE_CNT: sample_cnt_ff <= csr_data[5:0];
            vpc_pkg::REG_REQ_MATCH:  req_match_ff  <= csr_data[5:0];
            vpc_pkg::REG_UPD_RATE:   upd_rate_ff   <= csr_data;
            vpc_pkg::REG_FRM_WIDTH:  frm_width_ff  <= csr_data;
            vpc_pkg::REG_FRM_HEIGHT: frm_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic csr_frame;
   assign csr_frame = csr_valid && (csr_index == vpc_pkg::REG_FRM_WIDTH ||
                                    csr_index == vpc_pkg::REG_FRM_HEIGHT);

   // Raster position wrap at accept
   logic [8:0] cx, cy;
   always_comb begin
      cx = 9'(col_ff);
      cy = 9'(line_ff);
      if (cx >= w_eff) begin
         cx = 9'd0;
         cy = cy + 9'd1;
      end
      if (cy >= h_eff) begin
         cy = 9'd0;
      end
   end

   // Capture the item
   logic [16:0] idx_full;
   assign idx_full = 17'(cy) * 17'(w_eff) + 17'(cx);
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff        <= req_opcode;
         pix_ff       <= {req_red, req_green, req_blue};
         lslot_ff     <= req_load_slot;
         laddr_ff     <= req_load_address;
         dir_ff       <= req_nbr_dir;
         x_ff         <= cx[7:0];
         y_ff         <= cy[7:0];
         idx_ff       <= idx_full[15:0];
      end
   end

   // Update decisions and slots (small draw remainders by iterative subtract)
   // Remainders come from a shared serial unit below.
   logic        hit;
   logic [15:0] rem_self, rem_nbr, rem_sslot, rem_nslot;

   // Modulo unit: four remainders by restoring division, one bit per cycle
   logic [4:0]  mod_bit_ff;
   logic        mod_busy_ff;
   logic [15:0] mq_ff [4];
   logic [15:0] mr_ff [4];
   logic [8:0]  mdiv [4];
   assign mdiv[0] = rate;
   assign mdiv[1] = rate;
   assign mdiv[2] = 9'(n_eff);
   assign mdiv[3] = 9'(n_eff);
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_busy_ff <= 1'b0;
         mod_bit_ff  <= 5'd0;
      end else if (accept) begin
         mod_busy_ff <= 1'b1;
         mod_bit_ff  <= 5'd16;
      end else if (mod_busy_ff) begin
         mod_bit_ff  <= mod_bit_ff - 5'd1;
         mod_busy_ff <= (mod_bit_ff != 5'd1);
      end
   end
   always_ff @(posedge clock) begin
      if (accept) begin
         mq_ff[0] <= req_self_draw;
         mq_ff[1] <= req_nbr_draw;
         mq_ff[2] <= req_self_slot_draw;
         mq_ff[3] <= req_nbr_slot_draw;
         for (int i = 0; i < 4; i++) begin
            mr_ff[i] <= 16'd0;
         end
      end else if (mod_busy_ff) begin
         for (int i = 0; i < 4; i++) begin
            logic [16:0] t;
            t = {mr_ff[i], mq_ff[i][15]};
            if (t >= 17'(mdiv[i])) begin
               t = t - 17'(mdiv[i]);
            end
            mr_ff[i] <= t[15:0];
            mq_ff[i] <= {mq_ff[i][14:0], 1'b0};
         end
      end
   end
   assign rem_self  = mr_ff[0];
   assign rem_nbr   = mr_ff[1];
   assign rem_sslot = mr_ff[2];
   assign rem_nslot = mr_ff[3];

   // Neighbor coordinates, clamped at the frame edges
   logic [8:0]  nx, ny;
   logic [16:0] nidx;
   always_comb begin
      nx = 9'(x_ff);
      ny = 9'(y_ff);
      case (dir_ff)
         3'd0, 3'd6, 3'd7: nx = (x_ff == 8'd0) ? 9'd0 : 9'(x_ff) - 9'd1;
         3'd2, 3'd3, 3'd4: nx = (9'(x_ff) + 9'd1 > w_eff - 9'd1) ? w_eff - 9'd1 : 9'(x_ff) + 9'd1;
         default: ;
      endcase
      case (dir_ff)
         3'd0, 3'd1, 3'd2: ny = (y_ff == 8'd0) ? 9'd0 : 9'(y_ff) - 9'd1;
         3'd4, 3'd5, 3'd6: ny = (9'(y_ff) + 9'd1 > h_eff - 9'd1) ? h_eff - 9'd1 : 9'(y_ff) + 9'd1;
         default: ;
      endcase
      nidx = 17'(ny) * 17'(w_eff) + 17'(nx);
   end

   // Memory port control
   logic            ram_we;
   logic [AD_W-1:0] ram_addr;
   logic [23:0]     ram_rd;
   logic            load_ok;
   assign load_ok = (32'(lslot_ff) < MAX_SAMPLES) &&
                    (32'(laddr_ff) < 32'(w_eff) * 32'(h_eff));

   vpc_ram #(.WIDTH(vpc_pkg::PIX_W), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (pix_ff),
      .rd_data (ram_rd)
   );

   vpc_match u_match (
      .clock          (clock),
      .color_mode     (color_mode_ff),
      .dist_threshold (dist_thr_ff),
      .pixel          (pix_ff),
      .sample         (ram_rd),
      .hit_ff         (hit)
   );

   // Sequencer next state and outputs
   logic done_match;
   assign done_match = (7'(match_ff) >= 7'(req_match_ff)) || (slot_ff >= n_eff);
   always_comb begin
      state_in  = state_ff;
      slot_in   = slot_ff;
      match_in  = match_ff;
      ram_we    = 1'b0;
      ram_addr  = AD_W'({SL_W'(slot_ff), PL_W'(idx_ff)});
      rsp_load  = 1'b0;
      req_stall = 1'b1;
      col_in    = col_ff;
      line_in   = line_ff;
      case (state_ff)
         vpc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (accept) begin
               slot_in  = 7'd0;
               match_in = 6'd0;
               if (req_opcode == vpc_pkg::OP_LOAD) begin
                  state_in = vpc_pkg::ST_SELF_WR;
               end else begin
                  state_in = vpc_pkg::ST_READ;
                  // Advance the raster position
                  if (cx + 9'd1 >= w_eff) begin
                     col_in  = 8'd0;
                     line_in = (cy + 9'd1 >= h_eff) ? 8'd0 : 8'(cy + 9'd1);
                  end else begin
                     col_in  = 8'(cx + 9'd1);
                     line_in = cy[7:0];
                  end
               end
            end
         end
         vpc_pkg::ST_READ: begin
            // Issue a read unless testing is finished
            if (done_match) begin
               state_in = vpc_pkg::ST_SELF_WR;
            end else begin
               state_in = vpc_pkg::ST_COMPARE;
            end
         end
         vpc_pkg::ST_COMPARE: begin
            // Sample read registered; wait for the registered hit
            state_in = vpc_pkg::ST_OUT;
         end
         vpc_pkg::ST_OUT: begin
            if (hit) begin
               match_in = match_ff + 6'd1;
            end
            slot_in  = slot_ff + 7'd1;
            state_in = vpc_pkg::ST_READ;
         end
         vpc_pkg::ST_SELF_WR: begin
            if (op_ff == vpc_pkg::OP_LOAD) begin
               ram_addr = AD_W'({SL_W'(lslot_ff), PL_W'(laddr_ff)});
               ram_we   = load_ok;
               state_in = vpc_pkg::ST_IDLE;
            end else if (!mod_busy_ff) begin
               if (7'(match_ff) >= 7'(req_match_ff)) begin
                  ram_addr = AD_W'({SL_W'(rem_sslot), PL_W'(idx_ff)});
                  ram_we   = (rem_self == 16'd0);
                  state_in = vpc_pkg::ST_NBR_WR;
               end else if (out_free) begin
                  rsp_load = 1'b1;
                  state_in = vpc_pkg::ST_IDLE;
               end
            end
         end
         vpc_pkg::ST_NBR_WR: begin
            // Hold until the output register is free
            if (out_free) begin
               ram_addr = AD_W'({SL_W'(rem_nslot), PL_W'(nidx)});
               ram_we   = (rem_nbr == 16'd0);
               rsp_load = 1'b1;
               state_in = vpc_pkg::ST_IDLE;
            end
         end
         default: state_in = vpc_pkg::ST_IDLE;
      endcase
      if (csr_frame) begin
         col_in  = 8'd0;
         line_in = 8'd0;
      end
   end

   // Hold state, counters and result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vpc_pkg::ST_IDLE;
         col_ff       <= 8'd0;
         line_ff      <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         line_ff  <= line_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end
   always_ff @(posedge clock) begin
      slot_ff  <= slot_in;
      match_ff <= match_in;
      if (rsp_load) begin
         fg_ff   <= (7'(match_ff) < 7'(req_match_ff));
         mc_ff   <= match_ff;
         pidx_ff <= idx_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_foreground  = fg_ff;
   assign rsp_match_count = mc_ff;
   assign rsp_pixel_index = pidx_ff;

   `ASSERT_CLK(a_no_accept_busy, clock, reset, accept |-> state_ff == vpc_pkg::ST_IDLE, "item accepted while busy")
   `ASSERT_CLK(a_rsp_not_lost, clock, reset, rsp_load |-> !(rsp_valid_ff && rsp_stall), "result overwritten")
   `ASSERT_CLK(a_match_bound, clock, reset, (state_ff == vpc_pkg::ST_SELF_WR) |-> match_ff <= req_match_ff, "match count overran")
   `ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !rsp_valid_ff, "result valid after reset")
endmodule
`default_nettype wire

// ----- hw/rtl/vpc_ram.sv -----
// ----------------------------------------------------------------------------
// vpc_ram: generic single-port synchronous RAM
// One write and one read of the addressed word per cycle; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none
module vpc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write the addressed word when enabled, and read it
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

// ----- hw/rtl/vpc_match.sv -----
// ----------------------------------------------------------------------------
// vpc_match: sample distance test
// Registered test of one stored sample against the incoming color.
// ----------------------------------------------------------------------------
`default_nettype none
module vpc_match (
   input  wire logic                        clock,
   input  wire logic                        color_mode,
   input  wire logic [7:0]                  dist_threshold,
   input  wire logic [vpc_pkg::PIX_W-1:0]   pixel,
   input  wire logic [vpc_pkg::PIX_W-1:0]   sample,
   output logic                             hit_ff
);
   logic [7:0]  dr, dg, db;
   logic [18:0] dist_sq;
   logic [9:0]  t3;
   logic [19:0] t3_sq;
   logic        hit_in;

   // Compare in gray or RGB mode
   always_comb begin
      dr      = vpc_pkg::abs_diff(pixel[23:16], sample[23:16]);
      dg      = vpc_pkg::abs_diff(pixel[15:8], sample[15:8]);
      db      = vpc_pkg::abs_diff(pixel[7:0], sample[7:0]);
      dist_sq = 19'(16'(dr) * 16'(dr)) + 19'(16'(dg) * 16'(dg)) + 19'(16'(db) * 16'(db));
      t3      = 10'(dist_threshold) * 10'd3;
      t3_sq   = 20'(t3) * 20'(t3);
      hit_in  = color_mode ? (20'(dist_sq) < t3_sq) : (dr < dist_threshold);
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
   end
endmodule
`default_nettype wire

// ----- test/tb_vibe_pixel_classifier.sv -----
// ----------------------------------------------------------------------------
// tb_vibe_pixel_classifier: self-checking testbench of the pixel classifier
// Runs a set of frame configurations. Each one that requires a match fills every
// sample slot in use through load items, then sends directed and random classify and load items.
// A built-in predictor keeps its own sample store and raster position and
// checks every result field.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_vibe_pixel_classifier;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PLANE = 65536;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 100;

   typedef struct {
      logic        opcode;
      logic [7:0]  red, green, blue;
      logic [4:0]  load_slot;
      logic [15:0] load_address;
      logic [15:0] self_draw, self_slot_draw, nbr_draw, nbr_slot_draw;
      logic [2:0]  nbr_dir;
   } pix_item_type;

   typedef struct {
      logic        foreground;
      logic [5:0]  match_count;
      logic [15:0] pixel_index;
   } mask_result_type;

   // Neighbor offsets, clockwise from upper left.
   const int nbr_dx[8] = '{-1, 0, 1, 1, 1, 0, -1, -1};
   const int nbr_dy[8] = '{-1, -1, -1, 0, 1, 1, 1, 0};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_opcode = vpc_pkg::OP_CLASSIFY;
   logic [7:0]  req_red = '0, req_green = '0, req_blue = '0;
   logic [4:0]  req_load_slot = '0;
   logic [15:0] req_load_address = '0;
   logic [15:0] req_self_draw = '0, req_self_slot_draw = '0;
   logic [15:0] req_nbr_draw = '0, req_nbr_slot_draw = '0;
   logic [2:0]  req_nbr_dir = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic        rsp_foreground;
   logic [5:0]  rsp_match_count;
   logic [15:0] rsp_pixel_index;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [vpc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [vpc_pkg::CSR_DATA_W-1:0] csr_data = '0;

   vibe_pixel_classifier i_dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_opcode, .req_red, .req_green, .req_blue,
      .req_load_slot, .req_load_address, .req_self_draw, .req_self_slot_draw,
      .req_nbr_draw, .req_nbr_dir, .req_nbr_slot_draw,
      .rsp_valid, .rsp_stall, .rsp_foreground, .rsp_match_count, .rsp_pixel_index,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: register copies, raster position and sample store.
   logic        mode_q = 1'b1;
   logic [7:0]  thresh_q = 8'd20;
   logic [5:0]  nsamp_q = 6'd20;
   logic [5:0]  reqmatch_q = 6'd2;
   logic [8:0]  rate_q = 9'd16;
   logic [8:0]  width_q = 9'd256;
   logic [8:0]  height_q = 9'd256;
   int          col_pos = 0, row_pos = 0;
   logic [23:0] bg_samples [int];

   pix_item_type    pending_items [$];
   mask_result_type expected_masks [$];
   int           fail_count = 0;
   int           classify_sent = 0, load_sent = 0, masks_checked = 0, phase_count = 0;
   logic         hold_req = 1'b0;

   function automatic int clamp_size(input int v, input int hi);
      return (v < 1) ? 1 : ((v > hi) ? hi : v);
   endfunction

   function automatic bit sample_close(input logic [23:0] pix, input logic [23:0] s);
      int dr, dg, db, t3;
      dr = int'(pix[23:16]) - int'(s[23:16]);
      dg = int'(pix[15:8]) - int'(s[15:8]);
      db = int'(pix[7:0]) - int'(s[7:0]);
      t3 = 3 * int'(thresh_q);
      if (!mode_q) return ((dr < 0) ? -dr : dr) < int'(thresh_q);
      return dr * dr + dg * dg + db * db < t3 * t3;
   endfunction

   // Advance the predictor by one item; return 1 with the mask when one results.
   function automatic bit classify_pixel(input pix_item_type it, output mask_result_type m);
      int w, h, n, rate, idx, hit_count, slot, nx, ny;
      logic [23:0] pix;
      w = clamp_size(int'(width_q), 256);
      h = clamp_size(int'(height_q), 256);
      n = clamp_size(int'(nsamp_q), 32);
      rate = (rate_q == 0) ? 1 : int'(rate_q);
      pix = {it.red, it.green, it.blue};
      m = '{default: '0};
      if (it.opcode == vpc_pkg::OP_LOAD) begin
         if (int'(it.load_address) < w * h)
            bg_samples[int'(it.load_slot) * PLANE + int'(it.load_address)] = pix;
         return 1'b0;
      end
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      idx = row_pos * w + col_pos;
      hit_count = 0;
      slot = 0;
      while (hit_count < int'(reqmatch_q) && slot < n) begin
         if (!bg_samples.exists(slot * PLANE + idx))
            $error("stimulus reads unloaded sample slot %0d pixel %0d", slot, idx);
         else if (sample_close(pix, bg_samples[slot * PLANE + idx]))
            hit_count++;
         slot++;
      end
      if (hit_count >= int'(reqmatch_q)) begin
         if (int'(it.self_draw) % rate == 0)
            bg_samples[(int'(it.self_slot_draw) % n) * PLANE + idx] = pix;
         if (int'(it.nbr_draw) % rate == 0) begin
            nx = col_pos + nbr_dx[it.nbr_dir];
            ny = row_pos + nbr_dy[it.nbr_dir];
            nx = (nx < 0) ? 0 : ((nx > w - 1) ? w - 1 : nx);
            ny = (ny < 0) ? 0 : ((ny > h - 1) ? h - 1 : ny);
            bg_samples[(int'(it.nbr_slot_draw) % n) * PLANE + ny * w + nx] = pix;
         end
         m.foreground = 1'b0;
      end else begin
         m.foreground = 1'b1;
      end
      m.match_count = hit_count[5:0];
      m.pixel_index = idx[15:0];
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end
      return 1'b1;
   endfunction

   // Queue one item for the driver and record its expected mask.
   task automatic send_item(input pix_item_type it);
      mask_result_type m;
      if (classify_pixel(it, m)) begin
         expected_masks.push_back(m);
         classify_sent++;
      end else begin
         load_sent++;
      end
      pending_items.push_back(it);
   endtask

   function automatic logic [7:0] jitter(input logic [7:0] base, input int span);
      int v;
      v = int'(base) + $urandom_range(0, 2 * span) - span;
      return (v < 0) ? 8'd0 : ((v > 255) ? 8'd255 : v[7:0]);
   endfunction

   function automatic pix_item_type random_item(input logic [23:0] base, input int span);
      pix_item_type it;
      it.opcode = vpc_pkg::OP_CLASSIFY;
      it.red = jitter(base[23:16], span);
      it.green = jitter(base[15:8], span);
      it.blue = jitter(base[7:0], span);
      it.load_slot = 5'($urandom_range(0, 31));
      it.load_address = 16'($urandom_range(0, 65535));
      it.self_draw = 16'($urandom_range(0, 65535));
      it.self_slot_draw = 16'($urandom_range(0, 65535));
      it.nbr_draw = 16'($urandom_range(0, 65535));
      it.nbr_slot_draw = 16'($urandom_range(0, 65535));
      it.nbr_dir = 3'($urandom_range(0, 7));
      return it;
   endfunction

   task automatic wait_idle();
      while (pending_items.size() != 0 || expected_masks.size() != 0 || req_valid)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [vpc_pkg::CSR_IDX_W-1:0] idx, input logic [8:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         vpc_pkg::REG_COLOR_MODE: mode_q = value[0];
         vpc_pkg::REG_DIST_THR:   thresh_q = value[7:0];
         vpc_pkg::REG_SAMPLE_CNT: nsamp_q = value[5:0];
         vpc_pkg::REG_REQ_MATCH:  reqmatch_q = value[5:0];
         vpc_pkg::REG_UPD_RATE:   rate_q = value;
         vpc_pkg::REG_FRM_WIDTH:  begin width_q = value; col_pos = 0; row_pos = 0; end
         vpc_pkg::REG_FRM_HEIGHT: begin height_q = value; col_pos = 0; row_pos = 0; end
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Configure, load every slot in use unless no match is required, then send directed and random items.
   task automatic run_phase(input logic mode, input logic [7:0] thr, input logic [5:0] nsamp,
                            input logic [5:0] reqm, input logic [8:0] rate,
                            input logic [8:0] w, input logic [8:0] h,
                            input int nrand, input bit directed);
      int npix, n, span;
      logic [23:0] base;
      pix_item_type it;
      wait_idle();
      csr_write(vpc_pkg::REG_COLOR_MODE, 9'(mode));
      csr_write(vpc_pkg::REG_DIST_THR, 9'(thr));
      csr_write(vpc_pkg::REG_SAMPLE_CNT, 9'(nsamp));
      csr_write(vpc_pkg::REG_REQ_MATCH, 9'(reqm));
      csr_write(vpc_pkg::REG_UPD_RATE, rate);
      csr_write(vpc_pkg::REG_FRM_WIDTH, w);
      csr_write(vpc_pkg::REG_FRM_HEIGHT, h);
      phase_count++;
      npix = clamp_size(int'(w), 256) * clamp_size(int'(h), 256);
      n = clamp_size(int'(nsamp), 32);
      span = (thr > 8) ? 6 : 2;
      base = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255))};
      // No sample is read when no match is required.
      if (reqm != 6'd0)
         for (int s = 0; s < n; s++)
            for (int a = 0; a < npix; a++) begin
               it = random_item(base, span);
               it.opcode = vpc_pkg::OP_LOAD;
               it.load_slot = 5'(s);
               it.load_address = 16'(a);
               send_item(it);
            end
      if (directed) begin
         // Every neighbor direction with forced updates, then the color extremes.
         for (int d = 0; d < 8; d++) begin
            it = random_item(base, span);
            it.nbr_dir = 3'(d);
            it.self_draw = '0;
            it.nbr_draw = '0;
            it.self_slot_draw = 16'hFFFF;
            it.nbr_slot_draw = '0;
            send_item(it);
         end
         it = random_item(24'h000000, 0);
         send_item(it);
         it = random_item(24'hFFFFFF, 0);
         it.self_draw = 16'hFFFF;
         it.nbr_draw = 16'hFFFF;
         send_item(it);
         // Load outside the frame: ignored.
         it = random_item(24'hFFFFFF, 0);
         it.opcode = vpc_pkg::OP_LOAD;
         it.load_slot = 5'd31;
         it.load_address = 16'hFFFF;
         send_item(it);
      end
      for (int i = 0; i < nrand; i++) begin
         if (i == nrand / 3 && phase_count == 6) hold_req = 1'b1;
         if ($urandom_range(0, 9) < 7) begin
            it = random_item(base, span);
            if ($urandom_range(0, 3) == 0) it = random_item(base, 255);
         end else begin
            it = random_item(base, span);
            it.opcode = vpc_pkg::OP_LOAD;
            if ($urandom_range(0, 1) == 0) it.load_address = 16'($urandom_range(0, npix - 1));
         end
         send_item(it);
      end
   endtask

   // Driver: bursts of items separated by random gaps.
   int burst_left = 0, gap_left = 0;
   pix_item_type cur;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            cur = pending_items.pop_front();
            req_opcode <= cur.opcode;
            req_red <= cur.red;
            req_green <= cur.green;
            req_blue <= cur.blue;
            req_load_slot <= cur.load_slot;
            req_load_address <= cur.load_address;
            req_self_draw <= cur.self_draw;
            req_self_slot_draw <= cur.self_slot_draw;
            req_nbr_draw <= cur.nbr_draw;
            req_nbr_dir <= cur.nbr_dir;
            req_nbr_slot_draw <= cur.nbr_slot_draw;
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall: a duty cycle that changes over time, plus one long hold.
   int stall_pct = 0, stall_age = 0, hold_left = 0;
   bit hold_done = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b1;
      end else begin
         stall_age <= stall_age + 1;
         if (stall_age % 300 == 0) stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 70);
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= 500;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // Monitor: compare each accepted mask with the oldest expectation.
   mask_result_type exp_m;
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_masks.size() == 0) begin
            $error("unexpected mask for pixel %0d", rsp_pixel_index);
            fail_count++;
         end else begin
            exp_m = expected_masks.pop_front();
            masks_checked++;
            if (rsp_foreground !== exp_m.foreground) begin
               $error("foreground: expected %0d actual %0d", exp_m.foreground, rsp_foreground);
               fail_count++;
            end
            if (rsp_match_count !== exp_m.match_count) begin
               $error("match_count: expected %0d actual %0d", exp_m.match_count,
                      rsp_match_count);
               fail_count++;
            end
            if (rsp_pixel_index !== exp_m.pixel_index) begin
               $error("pixel_index: expected %0d actual %0d", exp_m.pixel_index,
                      rsp_pixel_index);
               fail_count++;
            end
         end
      end
   end

   // Watchdog.
   int cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_vibe_pixel_classifier: FAIL");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Color, moderate threshold, always update.
      run_phase(1'b1, 8'd20, 6'd4, 6'd2, 9'd1, 9'd4, 9'd3, 70, 1'b1);
      // Gray, zero threshold, zero frame and sample sizes.
      run_phase(1'b0, 8'd0, 6'd0, 6'd1, 9'd0, 9'd0, 9'd0, 30, 1'b1);
      // Color, maximum threshold, every sample required, rare update.
      run_phase(1'b1, 8'd255, 6'd32, 6'd32, 9'd256, 9'd2, 9'd1, 40, 1'b0);
      // Gray, oversize frame saturating, no matches required.
      run_phase(1'b0, 8'd255, 6'd1, 6'd0, 9'd2, 9'd300, 9'd300, 60, 1'b0);
      // Tall frame with more matches required than samples.
      run_phase(1'b1, 8'd10, 6'd1, 6'd2, 9'd3, 9'd1, 9'd16, 60, 1'b0);
      // Gray mid-size frame; the long receiver hold falls here.
      run_phase(1'b0, 8'd40, 6'd4, 6'd3, 9'd4, 9'd5, 9'd4, 160, 1'b1);
      // Color small frame, maximum register codes.
      run_phase(1'b1, 8'd30, 6'd63, 6'd2, 9'd511, 9'd2, 9'd1, 40, 1'b0);
      run_phase(1'b1, 8'd30, 6'd6, 6'd2, 9'd3, 9'd3, 9'd3, 120, 1'b0);
      wait_idle();
      $display("Covered %0d configurations: %0d classify and %0d load items, %0d masks checked.",
               phase_count, classify_sent, load_sent, masks_checked);
      if (fail_count == 0)
         $display("tb_vibe_pixel_classifier: PASS");
      else
         $display("tb_vibe_pixel_classifier: FAIL");
      $finish;
   end
endmodule
`default_nettype wire
